### rtl/mbrx_pkg.sv
`timescale 1ns / 1ps

package mbrx_pkg;

    // Input item operations
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_WORD     = 3'd0;
    localparam logic [2:0] KIND_OK       = 3'd1;
    localparam logic [2:0] KIND_CRC      = 3'd2;
    localparam logic [2:0] KIND_EXC      = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd4;
    localparam logic [2:0] KIND_OVERFLOW = 3'd5;

    // Function codes and CRC-16/MODBUS constants
    localparam logic [7:0]  FUNC_READ   = 8'h03;
    localparam logic [7:0]  FUNC_WRITE1 = 8'h06;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    // Fixed frame lengths
    localparam logic [8:0] LEN_WRITE1 = 9'd8;
    localparam logic [8:0] LEN_EXC    = 9'd5;
    localparam logic [8:0] LEN_READ_EXTRA = 9'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] expect_slave;
        logic [6:0] expect_func;
        logic [7:0] rx_byte;
        logic [7:0] tick_units;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] word_value;
        logic [4:0]  word_index;
        logic [7:0]  exception_code;
        logic [7:0]  func_code;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CRC2,
        ST_RD,
        ST_WORD,
        ST_STAT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic crc2;
        logic rd;
        logic put_word;
        logic put_status;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_crc2;
        logic has_status;
        logic has_words;
        logic out_free;
        logic last_word;
    } dp_stat_t;

endpackage

### rtl/mbrx_ctrl.sv
`timescale 1ns / 1ps

module mbrx_ctrl
    import mbrx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.need_crc2)
                begin
                    state_next = ST_CRC2;
                end
                else if (stat.has_words)
                begin
                    state_next = ST_RD;
                end
                else if (stat.has_status)
                begin
                    state_next = ST_STAT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CRC2:
            begin
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                state_next = ST_WORD;
            end
            ST_WORD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_word ? ST_STAT : ST_RD;
                end
            end
            ST_STAT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_CRC2:
            begin
                cmd.crc2 = 1'b1;
            end
            ST_RD:
            begin
                cmd.rd = 1'b1;
            end
            ST_WORD:
            begin
                cmd.put_word = stat.out_free;
            end
            ST_STAT:
            begin
                cmd.put_status = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/mbrx_dpath.sv
`timescale 1ns / 1ps

module mbrx_dpath
    import mbrx_pkg::*;
#(
    parameter int MAX_REGS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    in_item,
    input  ctrl_cmd_t   cmd,
    input  logic        out_ready,
    input  logic [15:0] response_timeout,
    input  logic        word_order,
    output dp_stat_t    stat,
    output logic        out_valid,
    output out_item_t   out_item
);

    localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CW = $clog2(MAX_REGS + 1);
    localparam logic [8:0] MAX_BYTES = 9'(2 * MAX_REGS);
    localparam logic [8:0] CAPACITY  = 9'(2 * MAX_REGS + 5);
    localparam logic [7:0] REG_LIMIT = 8'(MAX_REGS);

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Item register
    in_item_t item_reg;

    // Frame state
    logic        armed_reg, armed_next;
    logic        aligned_reg, aligned_next;
    logic [7:0]  want_slave_reg, want_slave_next;
    logic [6:0]  want_func_reg, want_func_next;
    logic [7:0]  prev_reg, prev_next;
    logic        have_prev_reg, have_prev_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [8:0]  frame_len_reg, frame_len_next;
    logic [7:0]  got_func_reg, got_func_next;
    logic [7:0]  third_reg, third_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] tail_reg, tail_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [7:0]  half_reg, half_next;
    logic [2:0]  res_kind_reg, res_kind_next;
    logic [CW-1:0] idx_reg;

    // Word store
    logic [15:0] word_mem [MAX_REGS];
    logic [15:0] rd_data_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0] mem_wdata;

    // Output register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    // Combinational helpers
    logic [15:0] crc_in;
    logic [7:0]  crc_dat;
    logic [15:0] crc_out;
    logic [7:0]  b;
    logic [8:0]  p;
    logic [9:0]  p_plus2;
    logic [8:0]  bc_inc;
    logic [8:0]  off;
    logic [7:0]  off_half;
    logic [8:0]  fl_eff;
    logic        ovf;
    logic [17:0] tick_sum;
    logic [16:0] elapsed_sat;
    logic [7:0]  idx_inc;
    logic        need_crc2;
    logic        has_status;
    logic        has_words;

    // Shared CRC unit: header pair takes two passes, other bytes one
    assign crc_in  = (cmd.crc2 || aligned_reg) ? crc_reg : CRC_INIT;
    assign crc_dat = (cmd.crc2 || aligned_reg) ? item_reg.rx_byte : prev_reg;
    assign crc_out = crc_step(crc_in, crc_dat);

    assign b        = item_reg.rx_byte;
    assign p        = byte_count_reg;
    assign p_plus2  = {1'b0, p} + 10'd2;
    assign bc_inc   = p + 9'd1;
    assign off      = p - 9'd3;
    assign off_half = off[8:1];
    assign tick_sum = {1'b0, elapsed_reg} + {10'd0, item_reg.tick_units};
    assign elapsed_sat = tick_sum[17] ? 17'h1FFFF : tick_sum[16:0];

    // Execute one item against the frame state
    always_comb
    begin
        armed_next      = armed_reg;
        aligned_next    = aligned_reg;
        want_slave_next = want_slave_reg;
        want_func_next  = want_func_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        byte_count_next = byte_count_reg;
        frame_len_next  = frame_len_reg;
        got_func_next   = got_func_reg;
        third_next      = third_reg;
        crc_next        = crc_reg;
        tail_next       = tail_reg;
        elapsed_next    = elapsed_reg;
        half_next       = half_reg;
        res_kind_next   = res_kind_reg;
        need_crc2       = 1'b0;
        has_status      = 1'b0;
        has_words       = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = word_order ? {b, half_reg} : {half_reg, b};
        mem_waddr       = off_half[AW-1:0];
        fl_eff          = frame_len_reg;
        ovf             = 1'b0;

        case (item_reg.op)
            OP_START:
            begin
                // Re-arm and drop any frame in progress
                armed_next      = 1'b1;
                aligned_next    = 1'b0;
                want_slave_next = item_reg.expect_slave;
                want_func_next  = item_reg.expect_func;
                prev_next       = 8'd0;
                have_prev_next  = 1'b0;
                byte_count_next = 9'd0;
                frame_len_next  = 9'd0;
                got_func_next   = 8'd0;
                third_next      = 8'd0;
                crc_next        = CRC_INIT;
                tail_next       = 16'd0;
                elapsed_next    = 17'd0;
                half_next       = 8'd0;
            end
            OP_BYTE:
            begin
                if (armed_reg && !aligned_reg)
                begin
                    // Hunt for the slave / function header pair
                    if (have_prev_reg && prev_reg == want_slave_reg && b[6:0] == want_func_reg)
                    begin
                        aligned_next    = 1'b1;
                        got_func_next   = b;
                        crc_next        = crc_out;
                        need_crc2       = 1'b1;
                        byte_count_next = 9'd2;
                        if (b == FUNC_WRITE1)
                        begin
                            frame_len_next = LEN_WRITE1;
                        end
                        else if (b[7])
                        begin
                            frame_len_next = LEN_EXC;
                        end
                        else
                        begin
                            frame_len_next = 9'd0;
                        end
                    end
                    else
                    begin
                        prev_next      = b;
                        have_prev_next = 1'b1;
                    end
                end
                else if (armed_reg)
                begin
                    byte_count_next = bc_inc;
                    if (frame_len_reg != 9'd0 && p_plus2 >= {1'b0, frame_len_reg})
                    begin
                        // Trailing CRC, low byte first
                        if (p_plus2 == {1'b0, frame_len_reg})
                        begin
                            tail_next = {8'd0, b};
                        end
                        else
                        begin
                            tail_next = {b, tail_reg[7:0]};
                        end
                    end
                    else
                    begin
                        crc_next = crc_out;
                        if (p == 9'd2)
                        begin
                            third_next = b;
                            if (got_func_reg == FUNC_READ)
                            begin
                                if ({1'b0, b} > MAX_BYTES)
                                begin
                                    ovf = 1'b1;
                                end
                                else
                                begin
                                    fl_eff = {1'b0, b} + LEN_READ_EXTRA;
                                end
                            end
                        end
                        else if (got_func_reg == FUNC_READ && p >= 9'd3)
                        begin
                            // Pair data bytes into register words
                            if (!off[0])
                            begin
                                half_next = b;
                            end
                            else if (off_half < REG_LIMIT)
                            begin
                                mem_we = 1'b1;
                            end
                        end
                    end
                    frame_len_next = fl_eff;

                    if (ovf)
                    begin
                        armed_next    = 1'b0;
                        has_status    = 1'b1;
                        res_kind_next = KIND_OVERFLOW;
                    end
                    else if (fl_eff == 9'd0)
                    begin
                        if (bc_inc >= CAPACITY)
                        begin
                            armed_next    = 1'b0;
                            has_status    = 1'b1;
                            res_kind_next = KIND_OVERFLOW;
                        end
                    end
                    else if (bc_inc >= fl_eff)
                    begin
                        // Frame complete: check CRC and classify
                        armed_next = 1'b0;
                        has_status = 1'b1;
                        if (crc_reg != tail_next)
                        begin
                            res_kind_next = KIND_CRC;
                        end
                        else if (got_func_reg[7])
                        begin
                            res_kind_next = KIND_EXC;
                        end
                        else
                        begin
                            res_kind_next = KIND_OK;
                            has_words = (got_func_reg == FUNC_READ) && (third_next[7:1] != 7'd0);
                        end
                    end
                end
            end
            OP_TICK:
            begin
                if (armed_reg)
                begin
                    elapsed_next = elapsed_sat;
                    if (elapsed_sat > {1'b0, response_timeout})
                    begin
                        armed_next    = 1'b0;
                        has_status    = 1'b1;
                        res_kind_next = KIND_TIMEOUT;
                    end
                end
            end
            default:
            begin
                need_crc2 = 1'b0;
            end
        endcase
    end

    // Hold the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            aligned_reg    <= 1'b0;
            want_slave_reg <= 8'd0;
            want_func_reg  <= 7'd0;
            prev_reg       <= 8'd0;
            have_prev_reg  <= 1'b0;
            byte_count_reg <= 9'd0;
            frame_len_reg  <= 9'd0;
            got_func_reg   <= 8'd0;
            third_reg      <= 8'd0;
            crc_reg        <= CRC_INIT;
            tail_reg       <= 16'd0;
            elapsed_reg    <= 17'd0;
            half_reg       <= 8'd0;
            res_kind_reg   <= KIND_OK;
            idx_reg        <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                armed_reg      <= armed_next;
                aligned_reg    <= aligned_next;
                want_slave_reg <= want_slave_next;
                want_func_reg  <= want_func_next;
                prev_reg       <= prev_next;
                have_prev_reg  <= have_prev_next;
                byte_count_reg <= byte_count_next;
                frame_len_reg  <= frame_len_next;
                got_func_reg   <= got_func_next;
                third_reg      <= third_next;
                crc_reg        <= crc_next;
                tail_reg       <= tail_next;
                elapsed_reg    <= elapsed_next;
                half_reg       <= half_next;
                res_kind_reg   <= res_kind_next;
                idx_reg        <= '0;
            end
            else if (cmd.crc2)
            begin
                crc_reg <= crc_out;
            end
            else if (cmd.put_word)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Word store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            word_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= word_mem[idx_reg[AW-1:0]];
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put_word || cmd.put_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_word)
        begin
            out_item_reg.kind           <= KIND_WORD;
            out_item_reg.word_value     <= rd_data_reg;
            out_item_reg.word_index     <= 5'(idx_reg);
            out_item_reg.exception_code <= 8'd0;
            out_item_reg.func_code      <= got_func_reg;
            out_item_reg.last           <= 1'b0;
        end
        else if (cmd.put_status)
        begin
            out_item_reg.kind           <= res_kind_reg;
            out_item_reg.word_value     <= 16'd0;
            out_item_reg.word_index     <= 5'd0;
            out_item_reg.exception_code <= (res_kind_reg == KIND_EXC) ? third_reg : 8'd0;
            out_item_reg.func_code      <= got_func_reg;
            out_item_reg.last           <= 1'b1;
        end
    end

    // Status to controller
    assign idx_inc = 8'(idx_reg) + 8'd1;

    assign stat.need_crc2  = need_crc2;
    assign stat.has_status = has_status;
    assign stat.has_words  = has_words;
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.last_word  = idx_inc >= {1'b0, third_reg[7:1]};

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### rtl/modbus_rtu_response_receiver_top.sv
`timescale 1ns / 1ps

// Modbus RTU response receiver. A start word arms the block with the expected slave address
// and function code; received-byte words are searched for that header pair, the frame is
// checked with CRC-16/MODBUS against its trailing CRC (low byte first), and register words of
// a good read frame are emitted, their byte order set by word_order, followed by one status
// word (ok, CRC error, exception, timeout or overflow) carrying last. Tick words advance a
// response timer compared with response_timeout. One input word is handled at a time; each
// register word is read from the word store, whose read data is registered before it reaches
// the output register, and a waiting result holds the block until out_ready takes it. The
// word store holds MAX_REGS entries.
module modbus_rtu_response_receiver_top
    import mbrx_pkg::*;
#(
    parameter int MAX_REGS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_ORDER   = 1'b1;

    logic [15:0] timeout_reg;
    logic        order_reg;
    logic        cfg_write;
    ctrl_cmd_t   cmd;
    dp_stat_t    stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd1000;
            order_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                REG_ORDER:   order_reg   <= pwdata[0];
                default:     order_reg   <= order_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_ORDER:   prdata = {31'd0, order_reg};
            default:     prdata = 32'd0;
        endcase
    end

    mbrx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbrx_dpath #(
        .MAX_REGS (MAX_REGS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_item          (in_item),
        .cmd              (cmd),
        .out_ready        (out_ready),
        .response_timeout (timeout_reg),
        .word_order       (order_reg),
        .stat             (stat),
        .out_valid        (out_valid),
        .out_item         (out_item)
    );

`ifndef SYNTH
    // Register words never close a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_WORD |-> !out_item.last)
        else $error("register word flagged as last");

    // Every status word closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind != KIND_WORD |-> out_item.last)
        else $error("status word without last");

    // An accepted word is worked on before the next is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");
`endif

endmodule

### verif/modbus_rtu_response_receiver_top_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_response_receiver_top_tb;
    import mbrx_pkg::*;

    localparam int         MAX_REGS    = 32;
    localparam int         RX_CAPACITY = 2 * MAX_REGS + 5;
    localparam int         HOLD_CYCLES = 400;
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_ORDER   = 3'd4;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Words waiting to be offered, and results the parser owes
    in_item_t    line_words[$];
    out_item_t   due_results[$];
    logic [7:0]  frame_bytes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int tick_pct      = 0;
    int phase_count   = 0;
    int fault_count   = 0;
    int hold_asks     = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    // Parser copy: configuration and frame state
    logic [15:0] cfg_timeout    = 16'd1000;
    logic        cfg_word_order = 1'b0;
    logic        p_armed        = 1'b0;
    logic        p_aligned      = 1'b0;
    logic [7:0]  p_want_slave   = '0;
    logic [6:0]  p_want_func    = '0;
    logic [7:0]  p_prev         = '0;
    logic        p_have_prev    = 1'b0;
    logic [8:0]  p_count        = '0;
    logic [8:0]  p_len          = '0;
    logic [7:0]  p_got_func     = '0;
    logic [7:0]  p_third        = '0;
    logic [15:0] p_crc          = CRC_INIT;
    logic [15:0] p_tail         = '0;
    logic [16:0] p_elapsed      = '0;
    logic [7:0]  p_half         = '0;
    logic [15:0] p_store[MAX_REGS];

    modbus_rtu_response_receiver_top #(
        .MAX_REGS (MAX_REGS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        int          i;
        r = c ^ {8'h00, b};
        for (i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void note_result(input logic [2:0] kind, input logic [15:0] value,
                                        input logic [4:0] index, input logic [7:0] exc,
                                        input logic last);
        out_item_t r;
        r.kind           = kind;
        r.word_value     = value;
        r.word_index     = index;
        r.exception_code = exc;
        r.func_code      = p_got_func;
        r.last           = last;
        due_results.push_back(r);
    endfunction

    // Check the trailing CRC and release the frame's words and status
    function automatic void close_frame();
        int i;
        int words;
        p_armed = 1'b0;
        if (p_crc != p_tail)
        begin
            note_result(KIND_CRC, 16'h0, 5'd0, 8'h00, 1'b1);
            return;
        end
        if (p_got_func[7])
        begin
            note_result(KIND_EXC, 16'h0, 5'd0, p_third, 1'b1);
            return;
        end
        if (p_got_func == FUNC_READ)
        begin
            words = int'(p_third) / 2;
            for (i = 0; i < words && i < MAX_REGS; i++)
                note_result(KIND_WORD, p_store[i], i[4:0], 8'h00, 1'b0);
        end
        note_result(KIND_OK, 16'h0, 5'd0, 8'h00, 1'b1);
    endfunction

    function automatic void take_rx(input logic [7:0] b);
        int          pos;
        int          off;
        logic [15:0] w;
        // Hunt for the slave/function pair, dropping anything before it
        if (!p_aligned)
        begin
            if (p_have_prev && p_prev == p_want_slave && b[6:0] == p_want_func)
            begin
                p_aligned  = 1'b1;
                p_got_func = b;
                p_crc      = crc_fold(crc_fold(CRC_INIT, p_prev), b);
                p_count    = 9'd2;
                if (b == FUNC_WRITE1)
                    p_len = LEN_WRITE1;
                else if (b[7])
                    p_len = LEN_EXC;
                else
                    p_len = 9'd0;
            end
            else
            begin
                p_prev      = b;
                p_have_prev = 1'b1;
            end
            return;
        end
        pos     = int'(p_count);
        p_count = p_count + 9'd1;
        if (p_len != 0 && pos + 2 >= int'(p_len))
        begin
            // CRC arrives low byte first
            if (pos + 2 == int'(p_len))
                p_tail = {8'h00, b};
            else
                p_tail = {b, p_tail[7:0]};
        end
        else
        begin
            p_crc = crc_fold(p_crc, b);
            if (pos == 2)
            begin
                p_third = b;
                if (p_got_func == FUNC_READ)
                begin
                    if (int'(b) > 2 * MAX_REGS)
                    begin
                        p_armed = 1'b0;
                        note_result(KIND_OVERFLOW, 16'h0, 5'd0, 8'h00, 1'b1);
                        return;
                    end
                    p_len = {1'b0, b} + LEN_READ_EXTRA;
                end
            end
            else if (p_got_func == FUNC_READ && pos >= 3)
            begin
                // Pair data bytes into register words
                off = pos - 3;
                if (off % 2 == 0)
                    p_half = b;
                else
                begin
                    w = cfg_word_order ? {b, p_half} : {p_half, b};
                    if (off / 2 < MAX_REGS)
                        p_store[off / 2] = w;
                end
            end
        end
        // Unknown length: give up once the buffer would be exceeded
        if (p_len == 0)
        begin
            if (int'(p_count) >= RX_CAPACITY)
            begin
                p_armed = 1'b0;
                note_result(KIND_OVERFLOW, 16'h0, 5'd0, 8'h00, 1'b1);
            end
            return;
        end
        if (p_count >= p_len)
            close_frame();
    endfunction

    function automatic void advance_parser(input in_item_t w);
        int sum;
        if (w.op == OP_START)
        begin
            p_aligned    = 1'b0;
            p_prev       = 8'h00;
            p_have_prev  = 1'b0;
            p_count      = 9'd0;
            p_len        = 9'd0;
            p_got_func   = 8'h00;
            p_third      = 8'h00;
            p_crc        = CRC_INIT;
            p_tail       = 16'h0;
            p_half       = 8'h00;
            p_armed      = 1'b1;
            p_want_slave = w.expect_slave;
            p_want_func  = w.expect_func;
            p_elapsed    = 17'h0;
            return;
        end
        if (!p_armed)
            return;
        if (w.op == OP_BYTE)
            take_rx(w.rx_byte);
        else if (w.op == OP_TICK)
        begin
            sum = int'(p_elapsed) + int'(w.tick_units);
            if (sum > 'h1FFFF)
                sum = 'h1FFFF;
            p_elapsed = sum[16:0];
            if (p_elapsed > {1'b0, cfg_timeout})
            begin
                p_armed = 1'b0;
                note_result(KIND_TIMEOUT, 16'h0, 5'd0, 8'h00, 1'b1);
            end
        end
    endfunction

    function automatic void check_field(input string field, input int expected, input int actual);
        if (expected != actual)
        begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expected, actual);
        end
    endfunction

    // Queue one word; fields the operation does not use carry random bits
    function automatic void queue_word(input logic [1:0] op, input logic [7:0] a,
                                       input logic [6:0] f);
        in_item_t w;
        w    = {1'b0, $urandom};
        w.op = op;
        if (op == OP_START)
        begin
            w.expect_slave = a;
            w.expect_func  = f;
        end
        else if (op == OP_BYTE)
            w.rx_byte = a;
        else if (op == OP_TICK)
            w.tick_units = a;
        line_words.push_back(w);
        if (op != OP_SPARE)
            phase_count++;
    endfunction

    function automatic void open_frame(input logic [7:0] slave, input logic [7:0] func,
                                       input logic [7:0] third);
        frame_bytes.push_back(slave);
        frame_bytes.push_back(func);
        frame_bytes.push_back(third);
    endfunction

    // Send the collected bytes, with the odd tick mixed in
    function automatic void flush_bytes();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
        begin
            queue_word(OP_BYTE, frame_bytes[i], 7'd0);
            if ($urandom_range(0, 99) < tick_pct)
                queue_word(OP_TICK, 8'($urandom_range(0, 12)), 7'd0);
        end
        frame_bytes.delete();
    endfunction

    // Append the CRC, optionally break it, then send
    function automatic void queue_frame(input logic corrupt);
        logic [15:0] c;
        int          i;
        int          k;
        c = CRC_INIT;
        for (i = 0; i < frame_bytes.size(); i++)
            c = crc_fold(c, frame_bytes[i]);
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
        if (corrupt)
        begin
            k = frame_bytes.size() - 1 - int'($urandom_range(0, 1));
            frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
        end
        flush_bytes();
    endfunction

    function automatic void queue_full_read();
        logic [7:0] slave;
        int         i;
        slave = 8'($urandom);
        queue_word(OP_START, slave, FUNC_READ[6:0]);
        open_frame(slave, FUNC_READ, 8'(2 * MAX_REGS));
        for (i = 0; i < 2 * MAX_REGS; i++)
            frame_bytes.push_back(8'($urandom));
        queue_frame(1'b0);
    endfunction

    function automatic void queue_sequence();
        int         pick;
        int         r;
        int         i;
        int         n;
        logic [7:0] slave;
        logic [7:0] bc;
        logic [6:0] fn;
        pick  = $urandom_range(0, 99);
        r     = $urandom_range(0, 99);
        slave = 8'($urandom);
        bc    = (r < 70) ? 8'($urandom_range(0, 8)) :
                (r < 92) ? 8'($urandom_range(9, 63)) : 8'(2 * MAX_REGS);
        if (pick < 45)
        begin
            // Register read, CRC mostly good
            queue_word(OP_START, slave, FUNC_READ[6:0]);
            repeat ($urandom_range(0, 2)) queue_word(OP_BYTE, 8'($urandom), 7'd0);
            open_frame(slave, FUNC_READ, bc);
            for (i = 0; i < int'(bc); i++)
                frame_bytes.push_back(8'($urandom));
            queue_frame(pick >= 37);
        end
        else if (pick < 57)
        begin
            // Write single register echo
            queue_word(OP_START, slave, FUNC_WRITE1[6:0]);
            repeat ($urandom_range(0, 2)) queue_word(OP_BYTE, 8'($urandom), 7'd0);
            open_frame(slave, FUNC_WRITE1, 8'($urandom));
            repeat (3) frame_bytes.push_back(8'($urandom));
            queue_frame(pick >= 54);
        end
        else if (pick < 65)
        begin
            // Exception response
            fn = 7'($urandom);
            queue_word(OP_START, slave, fn);
            open_frame(slave, {1'b1, fn}, 8'($urandom));
            queue_frame(pick >= 63);
        end
        else if (pick < 70)
        begin
            // Byte count beyond the word store
            queue_word(OP_START, slave, FUNC_READ[6:0]);
            open_frame(slave, FUNC_READ, 8'($urandom_range(2 * MAX_REGS + 1, 255)));
            repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
            queue_frame(1'b0);
        end
        else if (pick < 78)
        begin
            // Wait for a reply that never comes
            queue_word(OP_START, slave, 7'($urandom));
            repeat ($urandom_range(1, 6)) queue_word(OP_TICK, 8'($urandom), 7'd0);
            repeat ($urandom_range(0, 2)) queue_word(OP_BYTE, 8'($urandom), 7'd0);
        end
        else if (pick < 88)
        begin
            // Cut the frame short; the next start abandons it
            queue_word(OP_START, slave, FUNC_READ[6:0]);
            open_frame(slave, FUNC_READ, bc);
            n = $urandom_range(0, int'(bc) + 1);
            for (i = 0; i < n; i++)
                frame_bytes.push_back(8'($urandom));
            flush_bytes();
        end
        else
        begin
            // Line noise over all operations
            repeat ($urandom_range(1, 6))
                queue_word(2'($urandom_range(0, 3)), 8'($urandom), 7'($urandom));
        end
    endfunction

    function automatic void fill_random(input int target);
        while (phase_count < target)
            queue_sequence();
    endfunction

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_TIMEOUT)
            cfg_timeout = data[15:0];
        else
            cfg_word_order = data[0];
    endtask

    // Hold until every word is taken and every result is back, then let the block settle
    task automatic wait_drained();
        do @(negedge clk); while (line_words.size() != 0 || in_valid || due_results.size() != 0);
        repeat (16) @(negedge clk);
    endtask

    task automatic begin_phase(input logic [15:0] limit, input logic order, input int sidle,
                               input int ridle, input int ticks);
        wait_drained();
        write_reg(REG_TIMEOUT, {16'h0, limit});
        write_reg(REG_ORDER, {31'h0, order});
        @(negedge clk);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        tick_pct      = ticks;
        phase_count   = 0;
    endtask

    // Sender: offer the next word, idling at random between words
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (line_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_item  <= line_words.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_taken != hold_asks)
        begin
            hold_taken <= hold_asks;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each result against the oldest one owed, then advance the parser copy
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: result kind %0d, expected none, actual %0h",
                             $time, out_item.kind, out_item);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, out_item.kind);
                    check_field("word_value", want.word_value, out_item.word_value);
                    check_field("word_index", want.word_index, out_item.word_index);
                    check_field("exception_code", want.exception_code, out_item.exception_code);
                    check_field("func_code", want.func_code, out_item.func_code);
                    check_field("last", want.last, out_item.last);
                end
            end
            if (in_valid && in_ready)
                advance_parser(in_item);
        end
    end

    initial
    begin
        logic [6:0] fn;
        int         i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ignored words, a write echo after a dropped byte, an odd read, an exception
        begin_phase(16'd1000, 1'b0, 0, 0, 0);
        queue_word(OP_TICK, 8'hFF, 7'd0);
        queue_word(OP_SPARE, 8'hFF, 7'h7F);
        queue_word(OP_START, 8'h11, FUNC_WRITE1[6:0]);
        queue_word(OP_BYTE, 8'h00, 7'd0);
        open_frame(8'h11, FUNC_WRITE1, 8'h00);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        queue_frame(1'b0);
        queue_word(OP_START, 8'hFF, FUNC_READ[6:0]);
        open_frame(8'hFF, FUNC_READ, 8'h03);
        frame_bytes.push_back(8'h12);
        frame_bytes.push_back(8'h34);
        frame_bytes.push_back(8'h56);
        queue_frame(1'b0);
        queue_word(OP_START, 8'h00, FUNC_READ[6:0]);
        open_frame(8'h00, 8'h83, 8'h04);
        queue_frame(1'b0);

        // Widest timeout, low byte first, no idling
        begin_phase(16'hFFFF, 1'b1, 0, 0, 4);
        queue_full_read();
        fill_random(75);

        // Sender idling; one frame of unknown length runs into overflow
        begin_phase(16'd300, 1'b0, 53, 0, 4);
        do fn = 7'($urandom); while (fn == FUNC_READ[6:0] || fn == FUNC_WRITE1[6:0]);
        queue_word(OP_START, 8'h5A, fn);
        open_frame(8'h5A, {1'b0, fn}, 8'($urandom));
        for (i = 0; i < 2 * MAX_REGS + 2; i++)
            frame_bytes.push_back(8'($urandom));
        flush_bytes();
        fill_random(75);

        // Zero timeout, receiver stalling, long hold-off to back the block up
        begin_phase(16'd0, 1'b1, 0, 53, 0);
        queue_full_read();
        fill_random(75);
        hold_asks++;

        // Both sides idling
        begin_phase(16'd1000, 1'b0, 36, 36, 4);
        fill_random(55);

        wait_drained();
        if (fault_count == 0)
            $display("modbus_rtu_response_receiver_top verification clean");
        else
            $display("modbus_rtu_response_receiver_top verification failed");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("modbus_rtu_response_receiver_top verification failed");
        $finish;
    end

endmodule
